FILE: rtl/skyap_pkg.sv
// ----------------------------------------------------------------------------
// skyap_pkg
// Shared constants, status codes and control types of the skyline packer.
// ----------------------------------------------------------------------------
package skyap_pkg;

	localparam int MAX_SEGMENTS_DEF = 32;
	localparam int COORD_BITS_DEF   = 16;
	localparam int SIZE_BITS        = 16;

	localparam logic [SIZE_BITS-1:0] ATLAS_WIDTH_RESET = 16'd1024;

	// result status codes
	localparam logic [2:0] ST_FIT  = 3'd0;
	localparam logic [2:0] ST_SPAN = 3'd1;
	localparam logic [2:0] ST_WIDE = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_OVF  = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic rd;
		logic scan_ev;
		logic decide;
		logic push_new;
		logic push_rem;
		logic build_ev;
		logic flush;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_clear;
		logic at_end;
		logic scan_hit;
		logic fit_point;
		logic fit_mode;
		logic placeable;
	} dp_stat_t;

endpackage

FILE: rtl/skyap_ctrl.sv
// ----------------------------------------------------------------------------
// skyap_ctrl
// Sequencer: clear, scan pass, decision, rebuild pass, commit, result handoff.
// ----------------------------------------------------------------------------
module skyap_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_free,
	input  skyap_pkg::dp_stat_t stat,
	output skyap_pkg::dp_cmd_t  cmd,
	output logic               in_ready,
	output logic               out_load
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_CLEAR    = 11'b00000000010,
		S_SCAN_RD  = 11'b00000000100,
		S_SCAN_EV  = 11'b00000001000,
		S_DECIDE   = 11'b00000010000,
		S_BUILD_RD = 11'b00000100000,
		S_BUILD_EV = 11'b00001000000,
		S_PUSH_NEW = 11'b00010000000,
		S_PUSH_REM = 11'b00100000000,
		S_FLUSH    = 11'b01000000000,
		S_DONE     = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_fire;
				if (in_fire) state_d = S_CLEAR;
			end
			S_CLEAR: begin
				cmd.clear = stat.need_clear;
				state_d   = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (stat.at_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				cmd.scan_ev = 1'b1;
				state_d     = stat.scan_hit ? S_DECIDE : S_SCAN_RD;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (!stat.placeable) state_d = S_DONE;
				else if (stat.fit_mode) state_d = S_BUILD_RD;
				else state_d = S_PUSH_NEW;
			end
			S_BUILD_RD: begin
				if (stat.fit_point) begin
					state_d = S_PUSH_NEW;
				end else if (stat.at_end) begin
					state_d = S_FLUSH;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_BUILD_EV;
				end
			end
			S_BUILD_EV: begin
				cmd.build_ev = 1'b1;
				state_d      = S_BUILD_RD;
			end
			S_PUSH_NEW: begin
				cmd.push_new = 1'b1;
				state_d      = S_PUSH_REM;
			end
			S_PUSH_REM: begin
				cmd.push_rem = 1'b1;
				state_d      = S_BUILD_RD;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: rtl/skyap_dp.sv
// ----------------------------------------------------------------------------
// skyap_dp
// Skyline store (two banks), scan accumulators, merge-on-push rebuild logic
// and the running extents.
// ----------------------------------------------------------------------------
module skyap_dp #(
	parameter int MAX_SEGMENTS = skyap_pkg::MAX_SEGMENTS_DEF,
	parameter int COORD_BITS   = skyap_pkg::COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  skyap_pkg::dp_cmd_t  cmd,
	output skyap_pkg::dp_stat_t stat,
	input  logic [15:0]         atlas_width,
	input  logic                start_new,
	input  logic [15:0]         image_width,
	input  logic [15:0]         image_height,
	output logic [15:0]         pos_x,
	output logic [15:0]         pos_y,
	output logic [2:0]          status,
	output logic [15:0]         used_width,
	output logic [15:0]         used_height
);

	localparam int CB   = COORD_BITS;
	localparam int SB   = skyap_pkg::SIZE_BITS;
	localparam int CNTW = $clog2(MAX_SEGMENTS + 3);
	localparam int IW   = $clog2(MAX_SEGMENTS);
	localparam int AW   = IW + 1;
	localparam int MEMD = 2 ** AW;
	localparam int EW   = (CB > SB) ? CB : SB;
	localparam int TW   = EW + 1;
	localparam logic [CNTW-1:0] MAX_C = CNTW'(MAX_SEGMENTS);

	typedef struct packed {
		logic [CB-1:0] h;
		logic [SB-1:0] s;
	} seg_t;

	seg_t mem [MEMD];
	seg_t rd_q;

	logic [SB-1:0]   w_q, h_q;
	logic            start_q, fresh_q, bank_q;
	logic [CNTW-1:0] count_q, j_q, wn_q, fit_i_q, span_i_q;
	logic [SB-1:0]   x_q, fit_s_q, span_sum_q, ls_q, ext_w_q;
	logic [CB-1:0]   y_q, tall_q, span_h_q, lh_q, ext_h_q;
	logic            fit_q, span_q, lv_q;
	logic [2:0]      status_q;

	logic [CB-1:0]   sel_h, rem_h, ph;
	logic [SB-1:0]   rem_s, ps, sum_n, clr_w, xw;
	logic [CNTW-1:0] sel_i;
	logic [TW-1:0]   top;
	logic            ovf, push_en, we, placed;
	logic [AW-1:0]   waddr;
	seg_t            wdata;
	logic [EW-1:0]   y_ext, ext_h_ext;

	assign sel_h = fit_q ? y_q : tall_q;
	assign sel_i = fit_q ? fit_i_q : span_i_q;
	assign rem_h = fit_q ? y_q : span_h_q;
	assign rem_s = fit_q ? (fit_s_q - w_q) : (span_sum_q - w_q);
	assign top   = TW'(sel_h) + TW'(h_q);
	assign ovf   = (top[TW-1:CB] != '0);
	assign sum_n = span_sum_q + rd_q.s;
	assign clr_w = start_q ? atlas_width : skyap_pkg::ATLAS_WIDTH_RESET;
	assign xw    = x_q + w_q;

	always_comb begin
		ph = rd_q.h;
		ps = rd_q.s;
		if (cmd.push_new) begin
			ph = top[CB-1:0];
			ps = w_q;
		end else if (cmd.push_rem) begin
			ph = rem_h;
			ps = rem_s;
		end
	end

	assign push_en = (cmd.push_new | cmd.push_rem | cmd.build_ev) && (ps != '0);

	// memory write: clear of entry 0, or spill of the pending segment into the other bank
	always_comb begin
		we    = 1'b0;
		waddr = {~bank_q, wn_q[IW-1:0]};
		wdata = '{h: lh_q, s: ls_q};
		if (cmd.clear) begin
			we    = 1'b1;
			waddr = {bank_q, {IW{1'b0}}};
			wdata = '{h: '0, s: clr_w};
		end else if (wn_q < MAX_C) begin
			if (push_en && lv_q && (lh_q != ph)) we = 1'b1;
			if (cmd.flush && lv_q) we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.rd) rd_q <= mem[{bank_q, j_q[IW-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q     <= image_width;
			h_q     <= image_height;
			start_q <= start_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q    <= 1'b1;
			bank_q     <= 1'b0;
			count_q    <= CNTW'(1);
			ext_w_q    <= '0;
			ext_h_q    <= '0;
			j_q        <= '0;
			wn_q       <= '0;
			fit_q      <= 1'b0;
			span_q     <= 1'b0;
			lv_q       <= 1'b0;
			status_q   <= skyap_pkg::ST_WIDE;
			x_q        <= '0;
			y_q        <= '0;
			tall_q     <= '0;
			span_sum_q <= '0;
			fit_i_q    <= '0;
			span_i_q   <= '0;
			fit_s_q    <= '0;
			span_h_q   <= '0;
			lh_q       <= '0;
			ls_q       <= '0;
		end else begin
			if (cmd.load) begin
				j_q        <= '0;
				x_q        <= '0;
				fit_q      <= 1'b0;
				span_q     <= 1'b0;
				span_sum_q <= '0;
				tall_q     <= '0;
			end
			if (cmd.clear) begin
				fresh_q <= 1'b0;
				count_q <= CNTW'(clr_w != '0);
				ext_w_q <= '0;
				ext_h_q <= '0;
			end
			if (cmd.scan_ev) begin
				if (rd_q.s >= w_q) begin
					fit_q   <= 1'b1;
					fit_i_q <= j_q;
					fit_s_q <= rd_q.s;
					y_q     <= rd_q.h;
				end else begin
					x_q <= x_q + rd_q.s;
					j_q <= j_q + CNTW'(1);
				end
				// spanning candidate: first prefix whose strides cover the width
				if (!span_q) begin
					span_sum_q <= sum_n;
					if (rd_q.h > tall_q) tall_q <= rd_q.h;
					if (sum_n >= w_q) begin
						span_q   <= 1'b1;
						span_i_q <= j_q;
						span_h_q <= rd_q.h;
					end
				end
			end
			if (cmd.decide) begin
				j_q  <= '0;
				wn_q <= '0;
				lv_q <= 1'b0;
				y_q  <= sel_h;
				if (!fit_q) x_q <= '0;
				if (!fit_q && !span_q) status_q <= skyap_pkg::ST_WIDE;
				else if (ovf) status_q <= skyap_pkg::ST_OVF;
				else status_q <= fit_q ? skyap_pkg::ST_FIT : skyap_pkg::ST_SPAN;
			end
			if (cmd.build_ev) j_q <= j_q + CNTW'(1);
			if (cmd.push_rem) j_q <= sel_i + CNTW'(1);
			if (push_en) begin
				if (lv_q && (lh_q == ph)) begin
					ls_q <= ls_q + ps;
				end else begin
					if (lv_q) wn_q <= wn_q + CNTW'(1);
					lh_q <= ph;
					ls_q <= ps;
					lv_q <= 1'b1;
				end
			end
			if (cmd.flush) begin
				if ((wn_q + CNTW'(lv_q)) > MAX_C) begin
					status_q <= skyap_pkg::ST_FULL;
				end else begin
					bank_q  <= ~bank_q;
					count_q <= wn_q + CNTW'(lv_q);
					if (xw > ext_w_q) ext_w_q <= xw;
					if (top[CB-1:0] > ext_h_q) ext_h_q <= top[CB-1:0];
				end
			end
		end
	end

	assign placed    = (status_q == skyap_pkg::ST_FIT) || (status_q == skyap_pkg::ST_SPAN);
	assign y_ext     = EW'(y_q);
	assign ext_h_ext = EW'(ext_h_q);

	assign pos_x       = placed ? x_q : '0;
	assign pos_y       = placed ? y_ext[15:0] : '0;
	assign status      = status_q;
	assign used_width  = ext_w_q;
	assign used_height = ext_h_ext[15:0];

	assign stat.need_clear = start_q | fresh_q;
	assign stat.at_end     = (j_q == count_q);
	assign stat.scan_hit   = (rd_q.s >= w_q);
	assign stat.fit_point  = fit_q && (j_q == fit_i_q);
	assign stat.fit_mode   = fit_q;
	assign stat.placeable  = (fit_q || span_q) && !ovf;

endmodule

FILE: rtl/skyline_atlas_packer.sv
// ----------------------------------------------------------------------------
// skyline_atlas_packer
// Skyline rectangle packer for a texture atlas, one placement per item.
// ----------------------------------------------------------------------------
// Each item is one image size; the block returns one result per item with the
// placed position, a status and the running used extent. A placed item goes
// through the scan, the decision, the skyline rebuild and the commit before
// its result is handed off and the next item is accepted; an item rejected as
// too wide or overflowing skips the rebuild. The skyline memory has a single
// read port with a registered read, so segments are read one at a time, each
// in a read state followed by an evaluate state. The next item is taken while
// a finished result still waits on the output. After reset the skyline is one
// zero-height segment of width 1024, whatever atlas_width is written later; a
// new atlas_width takes effect on the next item with start_new set.
module skyline_atlas_packer #(
	parameter int MAX_SEGMENTS = skyap_pkg::MAX_SEGMENTS_DEF,
	parameter int COORD_BITS   = skyap_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,     // atlas_width
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,      // image_width, image_height
	input  logic [0:0]  s_tuser,      // start_new
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,      // pos_x, pos_y, used_width, used_height
	output logic [2:0]  m_tuser       // status
);

	logic [15:0]         atlas_q;
	skyap_pkg::dp_cmd_t  cmd;
	skyap_pkg::dp_stat_t stat;
	logic                in_fire, out_load, out_free;
	logic [15:0]         pos_x, pos_y, used_w, used_h;
	logic [2:0]          st;
	logic [63:0]         out_data_q;
	logic [2:0]          out_user_q;
	logic                out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_q <= skyap_pkg::ATLAS_WIDTH_RESET;
		end else if (cfg_valid) begin
			atlas_q <= cfg_data;
		end
	end

	assign in_fire  = s_tvalid & s_tready;
	assign out_free = !out_valid_q || m_tready;

	skyap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (s_tready),
		.out_load (out_load)
	);

	skyap_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.atlas_width  (atlas_q),
		.start_new    (s_tuser[0]),
		.image_width  (s_tdata[15:0]),
		.image_height (s_tdata[31:16]),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.status       (st),
		.used_width   (used_w),
		.used_height  (used_h)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {used_h, used_w, pos_y, pos_x};
			out_user_q <= st;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

FILE: rtl/skyap_chk.sv
// ----------------------------------------------------------------------------
// skyap_chk
// Port-level checks on the result stream of the skyline packer.
// ----------------------------------------------------------------------------
module skyap_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [2:0]  m_tuser
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= skyap_pkg::ST_OVF))
		else $error("status code out of range");

	a_reject_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == skyap_pkg::ST_WIDE || m_tuser == skyap_pkg::ST_FULL
			|| m_tuser == skyap_pkg::ST_OVF)) |-> (m_tdata[31:0] == 32'd0))
		else $error("rejected item carries a position");

	a_span_at_left: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == skyap_pkg::ST_SPAN) |-> (m_tdata[15:0] == 16'd0))
		else $error("spanned item not at left edge");

	a_extent_covers_x: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == skyap_pkg::ST_FIT || m_tuser == skyap_pkg::ST_SPAN))
			|-> (m_tdata[47:32] >= m_tdata[15:0]))
		else $error("used width below placed x");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind skyline_atlas_packer skyap_chk u_skyap_chk (.*);
